// ===== sv/sbl_pkg.sv =====
package sbl_pkg;

  localparam int CFG_W          = 11;
  localparam int IDX_W          = 2;
  localparam int POS_W          = 10;
  localparam int EDGE_W         = 8;
  localparam int PIX_IN_W       = 8;
  localparam int LIM_W          = 2 * (CFG_W + 1);

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int SIZE_MIN       = 3;
  localparam int SIZE_RESET     = 100;
  localparam int THR_RESET      = 100;

  localparam logic [EDGE_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [EDGE_W-1:0] EDGE_OFF = 8'h00;

  typedef enum logic [IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             interior;
    logic             done;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } tag_t;

endpackage

// ===== sv/sobel_edge_threshold.sv =====
// Order: a result leaves after the pixel one row and one column past its center is taken.
// Throughput: one pixel per cycle while the output is not stalled; the line stores take
// one read and one write per cycle each, and the gradient runs in a three-stage pipeline
// behind the window. Reset: position counters and window clear to zero, registers
// return to 100, line stores are not cleared and hold nothing defined until written.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = sbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sbl_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = sbl_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sbl_pkg::PIX_IN_W-1:0] pixel_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sbl_pkg::EDGE_W-1:0]   edge_res_o,
  output logic [sbl_pkg::POS_W-1:0]    center_col_o,
  output logic [sbl_pkg::POS_W-1:0]    center_row_o,
  output logic                         frame_done_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sbl_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [sbl_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int CfgW = sbl_pkg::CFG_W;
  localparam int LimW = sbl_pkg::LIM_W;
  localparam int WD_W = ($clog2(MAX_WIDTH + 1) > CfgW) ? $clog2(MAX_WIDTH + 1) : CfgW;
  localparam int HT_W = ($clog2(MAX_HEIGHT + 1) > CfgW) ? $clog2(MAX_HEIGHT + 1) : CfgW;
  localparam int ThrW = CfgW + 1;

  logic [CfgW-1:0]       width_q, height_q, thr_q;
  logic [WD_W-1:0]       width_ext, width_use;
  logic [HT_W-1:0]       height_ext, height_use;
  logic [ThrW-1:0]       thr_inc;
  logic [LimW-1:0]       lim_q, lim_d;

  logic                  win_valid, grad_ready;
  logic [PIXEL_BITS-1:0] lcol [3];
  logic [PIXEL_BITS-1:0] rcol [3];
  logic [PIXEL_BITS-1:0] ctop, cbot;
  sbl_pkg::tag_t         tag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(sbl_pkg::SIZE_RESET);
      height_q <= CfgW'(sbl_pkg::SIZE_RESET);
      thr_q    <= CfgW'(sbl_pkg::THR_RESET);
      lim_q    <= LimW'((sbl_pkg::THR_RESET + 1) * (sbl_pkg::THR_RESET + 1));
    end else begin
      lim_q <= lim_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sbl_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg_data_i;
          sbl_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i;
          sbl_pkg::CFG_EDGE_THRESHOLD: thr_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign thr_inc = ThrW'(thr_q) + ThrW'(1);
  assign lim_d   = LimW'(thr_inc) * LimW'(thr_inc);

  always_comb begin
    width_ext  = WD_W'(width_q);
    height_ext = HT_W'(height_q);
    if (width_ext < WD_W'(sbl_pkg::SIZE_MIN)) begin
      width_use = WD_W'(sbl_pkg::SIZE_MIN);
    end else if (width_ext > WD_W'(MAX_WIDTH)) begin
      width_use = WD_W'(MAX_WIDTH);
    end else begin
      width_use = width_ext;
    end
    if (height_ext < HT_W'(sbl_pkg::SIZE_MIN)) begin
      height_use = HT_W'(sbl_pkg::SIZE_MIN);
    end else if (height_ext > HT_W'(MAX_HEIGHT)) begin
      height_use = HT_W'(MAX_HEIGHT);
    end else begin
      height_use = height_ext;
    end
  end

  sbl_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .WD_W       (WD_W),
    .HT_W       (HT_W)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .width_i       (width_use),
    .height_i      (height_use),
    .win_valid_o   (win_valid),
    .win_ready_i   (grad_ready),
    .lcol_o        (lcol),
    .ctop_o        (ctop),
    .cbot_o        (cbot),
    .rcol_o        (rcol),
    .tag_o         (tag)
  );

  sbl_grad #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_grad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_valid_i  (win_valid),
    .win_ready_o  (grad_ready),
    .lcol_i       (lcol),
    .ctop_i       (ctop),
    .cbot_i       (cbot),
    .rcol_i       (rcol),
    .tag_i        (tag),
    .lim_i        (lim_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_res_o   (edge_res_o),
    .center_col_o (center_col_o),
    .center_row_o (center_row_o),
    .frame_done_o (frame_done_o)
  );

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_valid |-> !in_stall_o)
    else $error("input stalled with window stage empty");

  a_stall_on_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid && !grad_ready |-> in_stall_o)
    else $error("request taken while window stage is blocked");

  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_res_o == sbl_pkg::EDGE_ON || edge_res_o == sbl_pkg::EDGE_OFF))
    else $error("edge result is neither on nor off");

endmodule

// ===== sv/sbl_ram.sv =====
module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sbl_window.sv =====
module sbl_window #(
  parameter int MAX_WIDTH  = sbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sbl_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = sbl_pkg::PIXEL_BITS_DEF,
  parameter int WD_W       = 11,
  parameter int HT_W       = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbl_pkg::PIX_IN_W-1:0]  pixel_i,
  input  logic                          frame_start_i,
  input  logic [WD_W-1:0]               width_i,
  input  logic [HT_W-1:0]               height_i,
  output logic                          win_valid_o,
  input  logic                          win_ready_i,
  output logic [PIXEL_BITS-1:0]         lcol_o [3],
  output logic [PIXEL_BITS-1:0]         ctop_o,
  output logic [PIXEL_BITS-1:0]         cbot_o,
  output logic [PIXEL_BITS-1:0]         rcol_o [3],
  output sbl_pkg::tag_t                 tag_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CMP_W = ((WD_W > HT_W) ? WD_W : HT_W) + 1;
  localparam int PosW  = sbl_pkg::POS_W;

  logic                  accept;
  logic                  s1_adv;
  logic                  s1_ready;

  logic [COL_W-1:0]      col_q, col_d, col_a, c0;
  logic [ROW_W-1:0]      row_q, row_d, row_a, r0;
  logic [CMP_W-1:0]      row_inc, col_next, row_next;
  logic [PIXEL_BITS-1:0] pix0;
  sbl_pkg::tag_t         tag0;

  logic                  s1v_q;
  logic [COL_W-1:0]      c1_q;
  logic [PIXEL_BITS-1:0] pix1_q;
  sbl_pkg::tag_t         tag1_q;
  logic                  fwd_q;
  logic [PIXEL_BITS-1:0] fwd_top_q, fwd_mid_q;

  logic [PIXEL_BITS-1:0] up_rdata, md_rdata;
  logic [PIXEL_BITS-1:0] eff_top, eff_mid;
  logic [PIXEL_BITS-1:0] win_q [6];

  assign s1_ready   = !s1v_q || win_ready_i;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;
  assign s1_adv     = s1v_q && win_ready_i;
  assign pix0       = PIXEL_BITS'(pixel_i);

  always_comb begin
    col_a = frame_start_i ? '0 : col_q;
    row_a = frame_start_i ? '0 : row_q;
    if (CMP_W'(col_a) >= CMP_W'(width_i)) begin
      c0      = '0;
      row_inc = CMP_W'(row_a) + CMP_W'(1);
    end else begin
      c0      = col_a;
      row_inc = CMP_W'(row_a);
    end
    if (row_inc >= CMP_W'(height_i)) begin
      r0 = '0;
    end else begin
      r0 = ROW_W'(row_inc);
    end

    col_next = CMP_W'(c0) + CMP_W'(1);
    row_next = CMP_W'(r0) + CMP_W'(1);
    if (col_next >= CMP_W'(width_i)) begin
      col_d = '0;
      if (row_next >= CMP_W'(height_i)) begin
        row_d = '0;
      end else begin
        row_d = ROW_W'(row_next);
      end
    end else begin
      col_d = COL_W'(col_next);
      row_d = r0;
    end

    tag0.interior = (CMP_W'(c0) >= CMP_W'(2)) && (CMP_W'(r0) >= CMP_W'(2));
    tag0.done     = (col_next == CMP_W'(width_i)) && (row_next == CMP_W'(height_i));
    tag0.col      = PosW'(c0 - COL_W'(1));
    tag0.row      = PosW'(r0 - ROW_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1v_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s1_ready) begin
        s1v_q <= in_valid_i;
      end
    end
  end

  // Bypass a read that hits the entry being written by the item leaving s1.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c1_q      <= c0;
      pix1_q    <= pix0;
      tag1_q    <= tag0;
      fwd_q     <= s1v_q && (c1_q == c0);
      fwd_top_q <= eff_mid;
      fwd_mid_q <= pix1_q;
    end
  end

  assign eff_top = fwd_q ? fwd_top_q : up_rdata;
  assign eff_mid = fwd_q ? fwd_mid_q : md_rdata;

  sbl_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (c1_q),
    .wdata_i (eff_mid),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (up_rdata)
  );

  sbl_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (c1_q),
    .wdata_i (pix1_q),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (md_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= eff_top;
      win_q[4] <= eff_mid;
      win_q[5] <= pix1_q;
    end
  end

  assign win_valid_o = s1v_q;
  assign lcol_o[0]   = win_q[0];
  assign lcol_o[1]   = win_q[1];
  assign lcol_o[2]   = win_q[2];
  assign ctop_o      = win_q[3];
  assign cbot_o      = win_q[5];
  assign rcol_o[0]   = eff_top;
  assign rcol_o[1]   = eff_mid;
  assign rcol_o[2]   = pix1_q;
  assign tag_o       = tag1_q;

endmodule

// ===== sv/sbl_grad.sv =====
module sbl_grad #(
  parameter int PIXEL_BITS = sbl_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         win_valid_i,
  output logic                         win_ready_o,
  input  logic [PIXEL_BITS-1:0]        lcol_i [3],
  input  logic [PIXEL_BITS-1:0]        ctop_i,
  input  logic [PIXEL_BITS-1:0]        cbot_i,
  input  logic [PIXEL_BITS-1:0]        rcol_i [3],
  input  sbl_pkg::tag_t                tag_i,
  input  logic [sbl_pkg::LIM_W-1:0]    lim_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sbl_pkg::EDGE_W-1:0]   edge_res_o,
  output logic [sbl_pkg::POS_W-1:0]    center_col_o,
  output logic [sbl_pkg::POS_W-1:0]    center_row_o,
  output logic                         frame_done_o
);

  localparam int SUM_W = PIXEL_BITS + 2;
  localparam int SQ_W  = 2 * SUM_W;
  localparam int MAG_W = (SQ_W + 1 > sbl_pkg::LIM_W) ? SQ_W + 1 : sbl_pkg::LIM_W;

  logic             take;
  logic             rdy2, rdy3, rdy4;
  logic [SUM_W-1:0] xa, xb, ya, yb;

  logic             v2_q, v3_q, v4_q;
  logic [SUM_W-1:0] sx_q, sy_q;
  sbl_pkg::tag_t    tag2_q, tag3_q, tag4_q;
  logic [SQ_W-1:0]  sqx_q, sqy_q;
  logic [MAG_W-1:0] mag;
  logic             edge_q;

  assign rdy4        = !v4_q || !out_stall_i;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign win_ready_o = rdy2;
  assign take        = win_valid_i && rdy2;

  always_comb begin
    xa = SUM_W'(rcol_i[0]) + (SUM_W'(rcol_i[1]) << 1) + SUM_W'(rcol_i[2]);
    xb = SUM_W'(lcol_i[0]) + (SUM_W'(lcol_i[1]) << 1) + SUM_W'(lcol_i[2]);
    ya = SUM_W'(lcol_i[2]) + (SUM_W'(cbot_i) << 1) + SUM_W'(rcol_i[2]);
    yb = SUM_W'(lcol_i[0]) + (SUM_W'(ctop_i) << 1) + SUM_W'(rcol_i[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= take && tag_i.interior;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  assign mag = MAG_W'(sqx_q) + MAG_W'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      sx_q   <= (xa >= xb) ? xa - xb : xb - xa;
      sy_q   <= (ya >= yb) ? ya - yb : yb - ya;
      tag2_q <= tag_i;
    end
    if (rdy3 && v2_q) begin
      sqx_q  <= sx_q * sx_q;
      sqy_q  <= sy_q * sy_q;
      tag3_q <= tag2_q;
    end
    if (rdy4 && v3_q) begin
      edge_q <= mag >= MAG_W'(lim_i);
      tag4_q <= tag3_q;
    end
  end

  assign out_valid_o  = v4_q;
  assign edge_res_o   = edge_q ? sbl_pkg::EDGE_ON : sbl_pkg::EDGE_OFF;
  assign center_col_o = tag4_q.col;
  assign center_row_o = tag4_q.row;
  assign frame_done_o = tag4_q.done;

endmodule

// ===== sim/sobel_edge_threshold_tb.sv =====
`timescale 1ns / 100ps

module sobel_edge_threshold_tb;

  localparam int EDGE_W   = sbl_pkg::EDGE_W;
  localparam int POS_W    = sbl_pkg::POS_W;
  localparam int CFG_W    = sbl_pkg::CFG_W;
  localparam int IDX_W    = sbl_pkg::IDX_W;
  localparam int PIX_IN_W = sbl_pkg::PIX_IN_W;

  localparam int NO_TYPED      = -1;
  localparam int N_DIRECTED    = 33;
  localparam int RANDOM_PIXELS = 1170;
  localparam int WIDE_PIXELS   = 300;
  localparam int TALL_PIXELS   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int MAX_REPORTS   = 40;

  typedef enum int {PIX_RANDOM, PIX_BINARY, PIX_SMOOTH} pix_mode_e;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_val;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic              done;
  } edge_item_t;

  typedef struct {
    bit                 is_cfg;
    sbl_pkg::cfg_idx_e  reg_idx;
    logic [CFG_W-1:0]   reg_val;
    logic [7:0]         pix;
    logic               fs;
    int                 typed_res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PIX_IN_W-1:0] pixel_i = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [EDGE_W-1:0]   edge_res_o;
  logic [POS_W-1:0]    center_col_o;
  logic [POS_W-1:0]    center_row_o;
  logic                frame_done_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i = '0;

  logic [CFG_W-1:0] width_reg = CFG_W'(sbl_pkg::SIZE_RESET);
  logic [CFG_W-1:0] height_reg = CFG_W'(sbl_pkg::SIZE_RESET);
  logic [CFG_W-1:0] thr_reg = CFG_W'(sbl_pkg::THR_RESET);
  logic [7:0]       upper_line [sbl_pkg::MAX_WIDTH_DEF] = '{default: 8'h00};
  logic [7:0]       middle_line [sbl_pkg::MAX_WIDTH_DEF] = '{default: 8'h00};
  logic [7:0]       win_pix [6] = '{default: 8'h00};
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  edge_item_t pending_edges [$];
  stim_row_t  directed_rows [N_DIRECTED];

  bit offering = 1'b0;
  bit cfg_offering = 1'b0;
  bit restart_due = 1'b0;
  bit gapless = 1'b0;
  bit pressure_go = 1'b0;
  logic hold_off = 1'b0;
  int rx_stall_left = 0;
  int rx_quiet = 0;
  int error_count = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int edges_seen = 0;
  int phase_count = 0;
  int cycle_count = 0;

  sobel_edge_threshold u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .edge_res_o    (edge_res_o),
    .center_col_o  (center_col_o),
    .center_row_o  (center_row_o),
    .frame_done_o  (frame_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_edges.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < sbl_pkg::SIZE_MIN) return sbl_pkg::SIZE_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit predict_edge(input logic [7:0] pix, input logic fs,
                                      output edge_item_t res);
    int unsigned w, h, c, r;
    int l0, l1, l2, m0, m2, r0, r1, r2, sx, sy, mag, lim;
    logic [7:0] top, mid;
    bit hit;
    w = clamp_dim(width_reg, sbl_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, sbl_pkg::MAX_HEIGHT_DEF);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    top = upper_line[c];
    mid = middle_line[c];
    res = '0;
    hit = 1'b0;
    if (c >= 2 && r >= 2) begin
      l0 = win_pix[0];
      l1 = win_pix[1];
      l2 = win_pix[2];
      m0 = win_pix[3];
      m2 = win_pix[5];
      r0 = top;
      r1 = mid;
      r2 = pix;
      sx = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
      sy = (l2 + 2 * m2 + r2) - (l0 + 2 * m0 + r0);
      mag = sx * sx + sy * sy;
      lim = (int'(thr_reg) + 1) * (int'(thr_reg) + 1);
      res.edge_val = (mag >= lim) ? sbl_pkg::EDGE_ON : sbl_pkg::EDGE_OFF;
      res.col = POS_W'(c - 1);
      res.row = POS_W'(r - 1);
      res.done = (c == w - 1) && (r == h - 1);
      hit = 1'b1;
    end
    upper_line[c] = mid;
    middle_line[c] = pix;
    win_pix[0] = win_pix[3];
    win_pix[1] = win_pix[4];
    win_pix[2] = win_pix[5];
    win_pix[3] = top;
    win_pix[4] = mid;
    win_pix[5] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result();
    edge_item_t want;
    if (pending_edges.size() == 0) begin
      report_mismatch($sformatf("result col %0d row %0d with no request pending",
                                center_col_o, center_row_o));
    end else begin
      want = pending_edges.pop_front();
      results_checked++;
      if (edge_res_o == sbl_pkg::EDGE_ON) edges_seen++;
      if (edge_res_o !== want.edge_val)
        report_mismatch($sformatf("edge_res %0d, predicted %0d at col %0d row %0d",
                                  edge_res_o, want.edge_val, want.col, want.row));
      if (center_col_o !== want.col)
        report_mismatch($sformatf("center_col %0d, predicted %0d", center_col_o, want.col));
      if (center_row_o !== want.row)
        report_mismatch($sformatf("center_row %0d, predicted %0d", center_row_o, want.row));
      if (frame_done_o !== want.done)
        report_mismatch($sformatf("frame_done %0b, predicted %0b at col %0d row %0d",
                                  frame_done_o, want.done, want.col, want.row));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (rx_quiet > 0) begin
        rx_quiet--;
        out_stall_i <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        rx_quiet = $urandom_range(50, 200);
        out_stall_i <= 1'b0;
      end else begin
        rx_stall_left = idle_len();
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // hold off the receiver so the pipeline backs up into the input
  initial begin
    wait (pressure_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic put_pixel(input logic [7:0] pix, input logic fs, input int typed);
    edge_item_t res;
    int gap;
    if (cfg_offering) begin
      cfg_valid_i <= 1'b0;
      cfg_offering = 1'b0;
    end
    in_valid_i <= 1'b1;
    pixel_i <= pix;
    frame_start_i <= fs;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_edge(pix, fs, res)) begin
      if (typed != NO_TYPED) res.edge_val = EDGE_W'(typed);
      pending_edges.push_back(res);
    end
    pixels_sent++;
    gap = idle_len();
    if (!gapless && gap != 0) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input sbl_pkg::cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_offering = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sbl_pkg::CFG_IMAGE_WIDTH: begin
        width_reg = val;
        restart_due = 1'b1;
      end
      sbl_pkg::CFG_IMAGE_HEIGHT: begin
        height_reg = val;
      end
      sbl_pkg::CFG_EDGE_THRESHOLD: begin
        thr_reg = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic settle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    if (cfg_offering) begin
      cfg_valid_i <= 1'b0;
      cfg_offering = 1'b0;
    end
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input bit each_frame, input bit noisy,
                           input pix_mode_e mode, input int base, input int amp);
    int k, frame_len, p;
    logic fs;
    frame_len = clamp_dim(width_reg, sbl_pkg::MAX_WIDTH_DEF) *
                clamp_dim(height_reg, sbl_pkg::MAX_HEIGHT_DEF);
    for (k = 0; k < n_items; k++) begin
      // restart after a width change so both line stores refill first
      fs = restart_due || (each_frame && (k % frame_len == 0)) ||
           (noisy && $urandom_range(0, 99) < 2);
      restart_due = 1'b0;
      case (mode)
        PIX_RANDOM: begin
          p = $urandom_range(0, 255);
        end
        PIX_BINARY: begin
          p = $urandom_range(0, 1) * 255;
        end
        default: begin
          p = base + int'($urandom_range(0, 2 * amp)) - amp;
          if (p < 0) p = 0;
          if (p > 255) p = 255;
        end
      endcase
      put_pixel(p[7:0], fs, NO_TYPED);
    end
  endtask

  initial begin
    int i, fw, fh, n_items, random_pixels, drain_cycles;
    bit prev_cfg;

    directed_rows = '{
      '{1'b1, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b1, sbl_pkg::CFG_IMAGE_HEIGHT,   11'd2,    8'd0,   1'b0, NO_TYPED},
      '{1'b1, sbl_pkg::CFG_EDGE_THRESHOLD, 11'd2047, 8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b1, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, int'(sbl_pkg::EDGE_OFF)},
      '{1'b1, sbl_pkg::CFG_EDGE_THRESHOLD, 11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b1, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, 1'b0, int'(sbl_pkg::EDGE_ON)},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, NO_TYPED},
      '{1'b0, sbl_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd128, 1'b0, int'(sbl_pkg::EDGE_OFF)}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_cfg = 1'b0;
    for (i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].is_cfg) begin
        if (!prev_cfg) settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        put_pixel(directed_rows[i].pix, directed_rows[i].fs, directed_rows[i].typed_res);
      end
      prev_cfg = directed_rows[i].is_cfg;
    end

    settle();
    write_reg(sbl_pkg::CFG_IMAGE_WIDTH, 11'd2047);
    write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, 11'd3);
    write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, CFG_W'($urandom_range(200, 900)));
    run_phase(WIDE_PIXELS, 1'b1, 1'b0, PIX_RANDOM, 0, 0);
    phase_count++;

    settle();
    write_reg(sbl_pkg::CFG_IMAGE_WIDTH, 11'd3);
    write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, 11'd2047);
    write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, CFG_W'($urandom_range(100, 600)));
    gapless = 1'b1;
    pressure_go = 1'b1;
    run_phase(TALL_PIXELS, 1'b0, 1'b0, PIX_SMOOTH, $urandom_range(0, 255), 120);
    gapless = 1'b0;
    phase_count++;

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      settle();
      if (random_pixels == 0 || $urandom_range(0, 99) < 60) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: write_reg(sbl_pkg::CFG_IMAGE_WIDTH, CFG_W'($urandom_range(3, 12)));
          6, 7:             write_reg(sbl_pkg::CFG_IMAGE_WIDTH, CFG_W'($urandom_range(13, 40)));
          default:          write_reg(sbl_pkg::CFG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 2)));
        endcase
      end
      if (random_pixels == 0 || $urandom_range(0, 99) < 60) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6:
            write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 8)));
          7:
            write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(9, 30)));
          default:
            write_reg(sbl_pkg::CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 2)));
        endcase
      end
      if (random_pixels == 0 || $urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 9))
          0:       write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, 11'd0);
          1:       write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, 11'd2047);
          2:       write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, 11'd1441);
          3:       write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, CFG_W'($urandom_range(0, 2047)));
          default: write_reg(sbl_pkg::CFG_EDGE_THRESHOLD, CFG_W'($urandom_range(0, 400)));
        endcase
      end
      fw = clamp_dim(width_reg, sbl_pkg::MAX_WIDTH_DEF);
      fh = clamp_dim(height_reg, sbl_pkg::MAX_HEIGHT_DEF);
      n_items = $urandom_range(1, 3) * fw * fh;
      if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, fw * fh - 1);
      if (n_items > RANDOM_PIXELS - random_pixels) n_items = RANDOM_PIXELS - random_pixels;
      gapless = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       run_phase(n_items, $urandom_range(0, 1), 1'b1, PIX_BINARY, 0, 0);
        1:       run_phase(n_items, $urandom_range(0, 1), 1'b1, PIX_RANDOM, 0, 0);
        default: run_phase(n_items, $urandom_range(0, 1), 1'b1, PIX_SMOOTH,
                           $urandom_range(0, 255), $urandom_range(0, 60));
      endcase
      gapless = 1'b0;
      random_pixels += n_items;
      phase_count++;
    end

    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    if (cfg_offering) begin
      cfg_valid_i <= 1'b0;
      cfg_offering = 1'b0;
    end
    drain_cycles = 0;
    while (pending_edges.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (pending_edges.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", pending_edges.size()));

    $display("Run covered %0d pixels in %0d configuration phases, sizes 3 to 1024",
             pixels_sent, phase_count);
    $display("Checked %0d interior results, %0d of them edges, %0d mismatches",
             results_checked, edges_seen, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
